### rtl/cigv_pkg.sv
package cigv_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_W = 28;
	localparam int SUM_W = 44;
	localparam int OP_W = 4;

	localparam logic [CFG_W-1:0] MIN_INTRON_RESET = CFG_W'(50);
	localparam logic [CFG_W-1:0] MAX_INTRON_RESET = CFG_W'(500000);

	// CIGAR op codes as packed in the low nibble of a BAM CIGAR word.
	localparam logic [OP_W-1:0] OP_M = 4'd0;
	localparam logic [OP_W-1:0] OP_I = 4'd1;
	localparam logic [OP_W-1:0] OP_D = 4'd2;
	localparam logic [OP_W-1:0] OP_N = 4'd3;
	localparam logic [OP_W-1:0] OP_S = 4'd4;
	localparam logic [OP_W-1:0] OP_H = 4'd5;
	localparam logic [OP_W-1:0] OP_P = 4'd6;

	// Configuration register indexes.
	localparam logic CFG_MIN_INTRON = 1'b0;
	localparam logic CFG_MAX_INTRON = 1'b1;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0,
		ERR_ZERO_LEN = 3'd1,
		ERR_BAD_INTRON = 3'd2,
		ERR_UNKNOWN_OP = 3'd3,
		ERR_UNFLANKED = 3'd4,
		ERR_SHORT = 3'd5
	} err_t;

	// Class of the most recent op that takes part in the flank check.
	typedef enum logic [1:0] {
		KEPT_NONE = 2'd0,
		KEPT_MATCH = 2'd1,
		KEPT_INDEL = 2'd2,
		KEPT_OTHER = 2'd3
	} kept_t;

	typedef struct packed {
		logic [WORD_W-1:0] cigar_word;
		logic last_op;
	} cigar_in_t;

	typedef struct packed {
		logic accepted;
		logic [2:0] error_code;
		logic [SUM_W-1:0] ref_span;
		logic [SUM_W-1:0] aligned_length;
		logic [SUM_W-1:0] query_length;
		logic [SUM_W-1:0] intron_total;
		logic spliced;
	} cigar_out_t;

	// Decoded view of one op, passed from the decoder to the record unit.
	typedef struct packed {
		logic [SUM_W-1:0] len;
		kept_t kept;
		logic add_ref;
		logic add_aln;
		logic add_qry;
		logic is_skip;
		logic zero_len;
		logic bad_skip;
		logic bad_op;
	} op_info_t;

	// The length is far narrower than a sum, so a carry out means overflow.
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
			input logic [SUM_W-1:0] len);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + {1'b0, len};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

### rtl/cigar_stream_validator_top.sv
// After the transfer of its last op, the result of a record passes the input register,
// then the record update into the output register. Throughput: one CIGAR op per cycle,
// set by the single record-update stage, unless a closing op waits on a full output.
// A record's result only waits on a stalled output when that output is still full.
// Reset (arst_n low, asynchronous) clears all record state and both pipeline valids,
// and loads the intron bounds with 50 and 500000.
module cigar_stream_validator_top #(
	parameter int OP_LENGTH_BITS = 28
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cigv_pkg::cigar_in_t in_item,
	output logic out_valid,
	input logic out_ready,
	output cigv_pkg::cigar_out_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [cigv_pkg::CFG_W-1:0] cfg_value
);
	import cigv_pkg::*;

	// Intron bounds. They are to be written only while the block is idle; the block does not enforce this.
	logic [CFG_W-1:0] min_intron_q;
	logic [CFG_W-1:0] max_intron_q;

	// Input register: one op waiting for the record update.
	logic valid_s1;
	cigar_in_t item_s1;

	// Output register: one finished record waiting for its transfer.
	logic out_valid_q;
	cigar_out_t out_item_q;

	op_info_t info;
	cigar_out_t result;
	logic step;

	assign cfg_ready = 1'b1;

	// An op that does not close its record never touches the output register,
	// so it moves on even while a result is stalled. A closing op moves on when
	// the output register is empty or is being emptied in this cycle.
	assign step = valid_s1 && (!item_s1.last_op || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_intron_q <= MIN_INTRON_RESET;
			max_intron_q <= MAX_INTRON_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_INTRON: min_intron_q <= cfg_value;
				CFG_MAX_INTRON: max_intron_q <= cfg_value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload only; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	cigv_op_decode #(
		.OP_LENGTH_BITS(OP_LENGTH_BITS)
	) u_decode (
		.cigar_word(item_s1.cigar_word),
		.min_intron(min_intron_q),
		.max_intron(max_intron_q),
		.info(info)
	);

	// Holds the running sums and the flank and error state of the open record.
	cigv_record u_record (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.last(item_s1.last_op),
		.info(info),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && item_s1.last_op) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_op) begin
			out_item_q <= result;
		end
	end

endmodule

### rtl/cigv_op_decode.sv
module cigv_op_decode #(
	parameter int OP_LENGTH_BITS = 28
) (
	input logic [cigv_pkg::WORD_W-1:0] cigar_word,
	input logic [cigv_pkg::CFG_W-1:0] min_intron,
	input logic [cigv_pkg::CFG_W-1:0] max_intron,
	output cigv_pkg::op_info_t info
);
	import cigv_pkg::*;

	logic [OP_W-1:0] op;
	logic [OP_LENGTH_BITS-1:0] len;
	logic [CFG_W-1:0] len_cfg;

	assign op = cigar_word[OP_W-1:0];
	assign len = cigar_word[OP_W +: OP_LENGTH_BITS];
	assign len_cfg = CFG_W'(len);

	always_comb begin
		info = '0;
		info.len = SUM_W'(len);
		info.zero_len = (len == '0);
		info.kept = KEPT_NONE;
		unique case (op) inside
			OP_M: begin
				info.add_ref = 1'b1;
				info.add_aln = 1'b1;
				info.add_qry = 1'b1;
				info.kept = KEPT_MATCH;
			end
			OP_I: begin
				info.add_qry = 1'b1;
				info.kept = KEPT_INDEL;
			end
			OP_D: begin
				info.add_ref = 1'b1;
				info.kept = KEPT_INDEL;
			end
			OP_N: begin
				info.add_ref = 1'b1;
				info.is_skip = 1'b1;
				info.bad_skip = (len_cfg > max_intron) || (len_cfg < min_intron);
				info.kept = KEPT_OTHER;
			end
			OP_S: begin
				info.add_qry = 1'b1;
				info.kept = KEPT_OTHER;
			end
			OP_H, OP_P: begin
				info.kept = KEPT_NONE;
			end
			default: begin
				info.bad_op = 1'b1;
			end
		endcase
	end

endmodule

### rtl/cigv_record.sv
module cigv_record (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic last,
	input cigv_pkg::op_info_t info,
	output cigv_pkg::cigar_out_t result
);
	import cigv_pkg::*;

	logic [SUM_W-1:0] ref_sum_q, aln_sum_q, qry_sum_q, int_sum_q;
	logic seen_skip_q;
	logic [1:0] first_err_q;
	kept_t prior_kept_q;
	logic flank_pending_q;
	logic flank_failed_q;

	logic [SUM_W-1:0] ref_sum_d, aln_sum_d, qry_sum_d, int_sum_d;
	logic seen_skip_d;
	logic [1:0] first_err_d;
	kept_t prior_kept_d;
	logic flank_pending_d;
	logic flank_failed_d;
	logic flank_final;
	err_t code;

	always_comb begin
		ref_sum_d = info.add_ref ? sat_add(ref_sum_q, info.len) : ref_sum_q;
		aln_sum_d = info.add_aln ? sat_add(aln_sum_q, info.len) : aln_sum_q;
		qry_sum_d = info.add_qry ? sat_add(qry_sum_q, info.len) : qry_sum_q;
		int_sum_d = info.is_skip ? sat_add(int_sum_q, info.len) : int_sum_q;
		seen_skip_d = seen_skip_q | info.is_skip;

		// Only the first parse error of the record is kept.
		first_err_d = first_err_q;
		if (first_err_q == 2'd0) begin
			if (info.zero_len)
				first_err_d = 2'(ERR_ZERO_LEN);
			else if (info.bad_skip)
				first_err_d = 2'(ERR_BAD_INTRON);
			else if (info.bad_op)
				first_err_d = 2'(ERR_UNKNOWN_OP);
		end

		prior_kept_d = prior_kept_q;
		flank_pending_d = flank_pending_q;
		flank_failed_d = flank_failed_q;
		if (info.kept != KEPT_NONE) begin
			if (flank_pending_q && info.kept != KEPT_MATCH)
				flank_failed_d = 1'b1;
			flank_pending_d = 1'b0;
			if (info.kept == KEPT_INDEL) begin
				if (prior_kept_q != KEPT_MATCH)
					flank_failed_d = 1'b1;
				flank_pending_d = 1'b1;
			end
			prior_kept_d = info.kept;
		end

		// An indel that closes the record has no match after it.
		flank_final = flank_failed_d | flank_pending_d;

		if (first_err_d != 2'd0)
			code = err_t'({1'b0, first_err_d});
		else if (flank_final)
			code = ERR_UNFLANKED;
		else if (aln_sum_d <= SUM_W'(1))
			code = ERR_SHORT;
		else
			code = ERR_OK;

		result.accepted = (code == ERR_OK);
		result.error_code = code;
		result.ref_span = ref_sum_d;
		result.aligned_length = aln_sum_d;
		result.query_length = qry_sum_d;
		result.intron_total = int_sum_d;
		result.spliced = seen_skip_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_sum_q <= '0;
			aln_sum_q <= '0;
			qry_sum_q <= '0;
			int_sum_q <= '0;
			seen_skip_q <= 1'b0;
			first_err_q <= 2'd0;
			prior_kept_q <= KEPT_NONE;
			flank_pending_q <= 1'b0;
			flank_failed_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				ref_sum_q <= '0;
				aln_sum_q <= '0;
				qry_sum_q <= '0;
				int_sum_q <= '0;
				seen_skip_q <= 1'b0;
				first_err_q <= 2'd0;
				prior_kept_q <= KEPT_NONE;
				flank_pending_q <= 1'b0;
				flank_failed_q <= 1'b0;
			end else begin
				ref_sum_q <= ref_sum_d;
				aln_sum_q <= aln_sum_d;
				qry_sum_q <= qry_sum_d;
				int_sum_q <= int_sum_d;
				seen_skip_q <= seen_skip_d;
				first_err_q <= first_err_d;
				prior_kept_q <= prior_kept_d;
				flank_pending_q <= flank_pending_d;
				flank_failed_q <= flank_failed_d;
			end
		end
	end

endmodule

### rtl/cigar_stream_validator_checker.sv
module cigar_stream_validator_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input cigv_pkg::cigar_out_t out_item
);
	import cigv_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped or changed while stalled");

	a_accept_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.accepted == (out_item.error_code == ERR_OK)) &&
			(out_item.error_code <= ERR_SHORT))
		else $error("accepted flag and error code disagree");

	a_accept_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.accepted |-> out_item.aligned_length > SUM_W'(1))
		else $error("accepted record with short aligned length");

	a_intron_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.intron_total <= out_item.ref_span) &&
			(out_item.spliced || out_item.intron_total == '0))
		else $error("intron total inconsistent with span or splice flag");

endmodule

bind cigar_stream_validator_top cigar_stream_validator_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item(out_item)
);

### verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cigv_pkg::*;

	// Op codes 7 through 15 have no case in the decoder, and the block must flag them.
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd7;
	localparam logic [OP_W-1:0] OP_LAST_UNUSED = 4'hF;
	localparam logic [CFG_W-1:0] LEN_MAX = {CFG_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_CEIL = {SUM_W{1'b1}};
	// Time allowed for a record's last op to pass the input and output registers.
	localparam int DRAIN_CYCLES = 4;
	// This many cycles with no transfer on any channel mean that the block has hung.
	localparam int STALL_LIMIT = 2000;
	// This many full-length match and skip pairs make one long record with large sums.
	localparam int LONG_PAIRS = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cigar_in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cigar_out_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_value = '0;

	// This is a shadow copy of the intron bounds. It is updated when a register write is
	// accepted.
	logic [CFG_W-1:0] intron_min = MIN_INTRON_RESET;
	logic [CFG_W-1:0] intron_max = MAX_INTRON_RESET;

	// This is a shadow copy of the record that the block is currently building.
	logic [SUM_W-1:0] rec_ref = '0;
	logic [SUM_W-1:0] rec_aligned = '0;
	logic [SUM_W-1:0] rec_query = '0;
	logic [SUM_W-1:0] rec_intron = '0;
	logic rec_spliced = 1'b0;
	err_t rec_first_err = ERR_OK;
	kept_t rec_prev_kept = KEPT_NONE;
	logic rec_indel_open = 1'b0;
	logic rec_flank_bad = 1'b0;

	cigar_out_t predicted_records[$];
	logic [WORD_W-1:0] pending_ops[$];

	int send_gap_pct = 0;
	int sink_stall_pct = 0;
	int ops_sent = 0;
	int records_sent = 0;
	int records_checked = 0;
	int bound_settings = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	cigar_stream_validator_top #(
		.OP_LENGTH_BITS(CFG_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_value(cfg_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] cigar_op(input logic [CFG_W-1:0] len,
			input logic [OP_W-1:0] code);
		return {len, code};
	endfunction

	// The sums clamp at their ceiling instead of wrapping.
	function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] acc,
			input logic [CFG_W-1:0] len);
		logic [SUM_W:0] wide;
		wide = (SUM_W+1)'(acc) + (SUM_W+1)'(len);
		return (wide > (SUM_W+1)'(SUM_CEIL)) ? SUM_CEIL : wide[SUM_W-1:0];
	endfunction

	task automatic report_failure(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// Appends one op to the record that is being assembled.
	task automatic queue_op(input logic [WORD_W-1:0] word);
		pending_ops = {pending_ops, word};
	endtask

	task automatic note_parse_error(input err_t code);
		if (rec_first_err == ERR_OK) begin
			rec_first_err = code;
		end
	endtask

	// Apply one accepted op to the shadow record. On the last op of a record, the verdict
	// and the sums are queued as the expected result, and the shadow record is cleared.
	task automatic predict_op(input cigar_in_t item);
		logic [CFG_W-1:0] len;
		logic [OP_W-1:0] op;
		kept_t kind;
		err_t verdict;
		cigar_out_t res;
		len = item.cigar_word[WORD_W-1:OP_W];
		op = item.cigar_word[OP_W-1:0];
		kind = KEPT_NONE;
		if (len == '0) begin
			note_parse_error(ERR_ZERO_LEN);
		end
		case (op)
			OP_M: begin
				rec_ref = add_clamped(rec_ref, len);
				rec_aligned = add_clamped(rec_aligned, len);
				rec_query = add_clamped(rec_query, len);
				kind = KEPT_MATCH;
			end
			OP_I: begin
				rec_query = add_clamped(rec_query, len);
				kind = KEPT_INDEL;
			end
			OP_D: begin
				rec_ref = add_clamped(rec_ref, len);
				kind = KEPT_INDEL;
			end
			OP_N: begin
				rec_ref = add_clamped(rec_ref, len);
				rec_intron = add_clamped(rec_intron, len);
				rec_spliced = 1'b1;
				// A skip that falls outside the bounds still counts toward the sums.
				if (len > intron_max || len < intron_min) begin
					note_parse_error(ERR_BAD_INTRON);
				end
				kind = KEPT_OTHER;
			end
			OP_S: begin
				rec_query = add_clamped(rec_query, len);
				kind = KEPT_OTHER;
			end
			OP_H, OP_P: ;
			default: begin
				note_parse_error(ERR_UNKNOWN_OP);
			end
		endcase
		// Hard clips and padding are transparent to the flank check, and so are unknown ops.
		// An indel must have a match on both sides among the remaining ops.
		if (kind != KEPT_NONE) begin
			if (rec_indel_open && kind != KEPT_MATCH) begin
				rec_flank_bad = 1'b1;
			end
			if (kind == KEPT_INDEL && rec_prev_kept != KEPT_MATCH) begin
				rec_flank_bad = 1'b1;
			end
			rec_indel_open = (kind == KEPT_INDEL);
			rec_prev_kept = kind;
		end
		if (item.last_op) begin
			if (rec_indel_open) begin
				rec_flank_bad = 1'b1;
			end
			if (rec_first_err != ERR_OK) begin
				verdict = rec_first_err;
			end else if (rec_flank_bad) begin
				verdict = ERR_UNFLANKED;
			end else if (rec_aligned <= 1) begin
				verdict = ERR_SHORT;
			end else begin
				verdict = ERR_OK;
			end
			res.accepted = (verdict == ERR_OK);
			res.error_code = verdict;
			res.ref_span = rec_ref;
			res.aligned_length = rec_aligned;
			res.query_length = rec_query;
			res.intron_total = rec_intron;
			res.spliced = rec_spliced;
			predicted_records = {predicted_records, res};
			rec_ref = '0;
			rec_aligned = '0;
			rec_query = '0;
			rec_intron = '0;
			rec_spliced = 1'b0;
			rec_first_err = ERR_OK;
			rec_prev_kept = KEPT_NONE;
			rec_indel_open = 1'b0;
			rec_flank_bad = 1'b0;
		end
	endtask

	// This task presents one op and returns at the rising edge where the transfer happens.
	// Valid is lowered only at a later falling edge, either by the next call (for an idle
	// gap) or by a hold. A step therefore never has more than one assignment to in_valid.
	task automatic send_op(input logic [WORD_W-1:0] word, input logic last);
		cigar_in_t item;
		item.cigar_word = word;
		item.last_op = last;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= item;
		do @(posedge clk); while (!in_ready);
		predict_op(item);
		ops_sent++;
		if (last) begin
			records_sent++;
		end
	endtask

	task automatic send_pending_record();
		foreach (pending_ops[i]) begin
			send_op(pending_ops[i], i == pending_ops.size() - 1);
		end
		pending_ops.delete();
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predicted_records.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// An op that is not the last of its record produces no result, so the block may still
	// be busy after the last result. Give the pipeline time to empty as well.
	task automatic settle_idle();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_bound(input logic idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_value <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_MIN_INTRON) begin
			intron_min = value;
		end else begin
			intron_max = value;
		end
	endtask

	task automatic set_intron_bounds(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		settle_idle();
		write_bound(CFG_MIN_INTRON, lo);
		write_bound(CFG_MAX_INTRON, hi);
		@(negedge clk);
		cfg_valid <= 1'b0;
		bound_settings++;
	endtask

	// Most lengths are short. Some are the extremes, and some are fully random so that
	// every length bit takes both values.
	function automatic logic [CFG_W-1:0] pick_len();
		case ($urandom_range(0, 19))
			0: return LEN_MAX;
			1: return 1;
			2, 3: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(1, 300));
		endcase
	endfunction

	// Most skips fall inside the current bounds, so that records can pass.
	function automatic logic [CFG_W-1:0] pick_skip_len();
		if (intron_min <= intron_max && $urandom_range(0, 3) != 0) begin
			return CFG_W'($urandom_range(32'(intron_max), 32'(intron_min)));
		end
		return pick_len();
	endfunction

	function automatic logic [WORD_W-1:0] noise_word();
		logic [OP_W-1:0] op;
		op = OP_W'($urandom_range(0, OP_LAST_UNUSED));
		return cigar_op(($urandom_range(0, 7) == 0) ? '0 : pick_len(), op);
	endfunction

	// Most records are well formed: optional clips, then a match, then indels or skips with
	// a match after each one, then an optional soft clip and padding. Some of these have one
	// op replaced by noise. The remaining records are pure noise.
	task automatic random_record();
		int n_mid;
		if ($urandom_range(0, 9) < 8) begin
			if ($urandom_range(0, 5) == 0) queue_op(cigar_op(pick_len(), OP_H));
			if ($urandom_range(0, 3) == 0) queue_op(cigar_op(pick_len(), OP_S));
			queue_op(cigar_op(pick_len(), OP_M));
			n_mid = $urandom_range(0, 5);
			repeat (n_mid) begin
				case ($urandom_range(0, 2))
					0: queue_op(cigar_op(pick_len(), OP_I));
					1: queue_op(cigar_op(pick_len(), OP_D));
					default: queue_op(cigar_op(pick_skip_len(), OP_N));
				endcase
				queue_op(cigar_op(pick_len(), OP_M));
			end
			if ($urandom_range(0, 3) == 0) queue_op(cigar_op(pick_len(), OP_S));
			if ($urandom_range(0, 5) == 0) queue_op(cigar_op(pick_len(), OP_P));
			if ($urandom_range(0, 9) == 0) begin
				pending_ops[$urandom_range(0, pending_ops.size() - 1)] = noise_word();
			end
		end else begin
			n_mid = $urandom_range(1, 6);
			repeat (n_mid) queue_op(noise_word());
		end
		send_pending_record();
	endtask

	// Short records that use the reset bounds (50 to 500000) and cover every op and
	// every verdict.
	task automatic test_directed_records();
		send_gap_pct = 0;
		sink_stall_pct = 0;
		// The simplest accepted record.
		queue_op(cigar_op(5, OP_M));
		send_pending_record();
		// Every legal op in one record. The insertion and the deletion each sit between
		// matches, the skip is at the lower bound, and the record ends on padding.
		queue_op(cigar_op(3, OP_S));
		queue_op(cigar_op(4, OP_M));
		queue_op(cigar_op(2, OP_I));
		queue_op(cigar_op(4, OP_M));
		queue_op(cigar_op(1, OP_D));
		queue_op(cigar_op(5, OP_M));
		queue_op(cigar_op(50, OP_N));
		queue_op(cigar_op(6, OP_M));
		queue_op(cigar_op(2, OP_H));
		queue_op(cigar_op(1, OP_P));
		send_pending_record();
		// A zero length is reported ahead of the unknown op code that comes with it.
		queue_op(cigar_op(0, OP_FIRST_UNUSED));
		queue_op(cigar_op(5, OP_M));
		send_pending_record();
		// An all-ones word has the full length and the highest unknown op code.
		queue_op(cigar_op(5, OP_M));
		queue_op({WORD_W{1'b1}});
		send_pending_record();
		// A skip one below the bound comes first, so it wins over the later zero length.
		queue_op(cigar_op(5, OP_M));
		queue_op(cigar_op(49, OP_N));
		queue_op(cigar_op(0, OP_M));
		send_pending_record();
		// The insertion is the first kept op, because the hard clip does not count.
		queue_op(cigar_op(2, OP_H));
		queue_op(cigar_op(3, OP_I));
		queue_op(cigar_op(5, OP_M));
		send_pending_record();
		// The deletion is the last kept op, and the record ends on a hard clip.
		queue_op(cigar_op(5, OP_M));
		queue_op(cigar_op(2, OP_D));
		queue_op(cigar_op(1, OP_H));
		send_pending_record();
		// An aligned length of one is too short.
		queue_op(cigar_op(1, OP_M));
		send_pending_record();
	endtask

	// Skips at each bound and one step outside it, for several settings of the bounds.
	// The settings include the extremes, equal bounds, and a minimum above the maximum.
	task automatic test_intron_bounds();
		logic [CFG_W-1:0] lows[5];
		logic [CFG_W-1:0] highs[5];
		logic [CFG_W-1:0] probes[4];
		lows = '{0, 777, 1000, LEN_MAX, 0};
		highs = '{LEN_MAX, 777, 10, LEN_MAX, 0};
		for (int s = 0; s < 5; s++) begin
			set_intron_bounds(lows[s], highs[s]);
			send_gap_pct = 0;
			sink_stall_pct = 0;
			probes = '{lows[s], highs[s], lows[s] - 1'b1, highs[s] + 1'b1};
			foreach (probes[p]) begin
				queue_op(cigar_op(8, OP_M));
				queue_op(cigar_op(probes[p], OP_N));
				queue_op(cigar_op(8, OP_M));
				send_pending_record();
			end
		end
	endtask

	// One long record of full-length matches and skips. It carries every length bit into
	// the upper bits of the reference, aligned, query and intron sums.
	task automatic test_long_record();
		set_intron_bounds(0, LEN_MAX);
		send_gap_pct = 0;
		sink_stall_pct = 0;
		repeat (LONG_PAIRS) begin
			send_op(cigar_op(LEN_MAX, OP_M), 1'b0);
			send_op(cigar_op(LEN_MAX, OP_N), 1'b0);
		end
		send_op(cigar_op(LEN_MAX, OP_M), 1'b1);
		hold_until_drained();
	endtask

	// Random records under one idling phase and one setting of the bounds. The sender
	// sometimes holds until the block has returned every result.
	task automatic test_random_records(input int gap_pct, input int stall_pct,
			input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi, input int quota);
		int start_ops;
		int recs;
		set_intron_bounds(lo, hi);
		send_gap_pct = gap_pct;
		sink_stall_pct = stall_pct;
		start_ops = ops_sent;
		recs = 0;
		while (ops_sent - start_ops < quota) begin
			random_record();
			recs++;
			if (recs % 20 == 19 || $urandom_range(0, 39) == 0) begin
				hold_until_drained();
			end
		end
		hold_until_drained();
	endtask

	// The receiver decides at each falling edge whether to stall during the next cycle.
	initial begin
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Each result transfer is compared field by field with the oldest expected record.
	initial begin : result_checker
		cigar_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (predicted_records.size() == 0) begin
					report_failure("result transfer with no record pending");
				end else begin
					want = predicted_records.pop_front();
					if (out_item.accepted !== want.accepted)
						report_failure($sformatf("record %0d accepted: got %0d expected %0d",
							records_checked, out_item.accepted, want.accepted));
					if (out_item.error_code !== want.error_code)
						report_failure($sformatf("record %0d error_code: got %0d expected %0d",
							records_checked, out_item.error_code, want.error_code));
					if (out_item.ref_span !== want.ref_span)
						report_failure($sformatf("record %0d ref_span: got %0d expected %0d",
							records_checked, out_item.ref_span, want.ref_span));
					if (out_item.aligned_length !== want.aligned_length)
						report_failure($sformatf("record %0d aligned_length: got %0d expected %0d",
							records_checked, out_item.aligned_length, want.aligned_length));
					if (out_item.query_length !== want.query_length)
						report_failure($sformatf("record %0d query_length: got %0d expected %0d",
							records_checked, out_item.query_length, want.query_length));
					if (out_item.intron_total !== want.intron_total)
						report_failure($sformatf("record %0d intron_total: got %0d expected %0d",
							records_checked, out_item.intron_total, want.intron_total));
					if (out_item.spliced !== want.spliced)
						report_failure($sformatf("record %0d spliced: got %0d expected %0d",
							records_checked, out_item.spliced, want.spliced));
					records_checked++;
				end
			end
		end
	end

	// Any transfer on any channel counts as progress. A long quiet stretch means a hang.
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles, %0d records still pending",
			STALL_LIMIT, predicted_records.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		// Reset is asserted once, from time zero, and released on a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_records();
		test_intron_bounds();
		test_long_record();
		// The idling phases are: none, sender gaps, receiver stalls, and both at once.
		test_random_records(0, 0, MIN_INTRON_RESET, MAX_INTRON_RESET, 450);
		test_random_records(83, 0, 0, LEN_MAX, 450);
		test_random_records(0, 83, CFG_W'($urandom_range(1, 100)),
			CFG_W'($urandom_range(200, 5000)), 450);
		test_random_records(33, 33, CFG_W'($urandom), CFG_W'($urandom), 450);

		settle_idle();
		if (predicted_records.size() != 0)
			report_failure($sformatf("%0d records never returned", predicted_records.size()));

		$display("Summary: %0d ops in %0d records sent, %0d results checked, %0d bound settings.",
			ops_sent, records_sent, records_checked, bound_settings);
		$display("Summary: the run included a long full-length record, skips at the bounds and four idling phases.");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
